// ===== hw/rtl/diagonal_value_sorter_top_defines.svh =====
// assertion macros used by the sorter controller
`ifndef DIAGONAL_VALUE_SORTER_TOP_DEFINES_SVH
`define DIAGONAL_VALUE_SORTER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DVS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle sorter check failed");

// next-cycle implication, checked outside reset
`define DVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle sorter check failed");

`endif

// ===== hw/rtl/dvs_pkg.sv =====
`default_nettype none
package dvs_pkg;

  localparam int DATA_W = 32;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic insert;
    logic shift;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_last;
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/diagonal_value_sorter_top.sv =====
// the first sorted value appears in the cycle after the last value of a run is taken
// throughput: one value per cycle while filling and start is high, then a burst of ELEMENT_COUNT results,
//   one per cycle, during which busy is high
// the result burst is paced by the shift of the insertion cell row, and the receiver cannot stall
// reset (rst, synchronous, active high) empties the cell row and returns to filling
`default_nettype none
module diagonal_value_sorter_top #(
  parameter int ELEMENT_COUNT = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // command side: a transfer happens when start is high and busy is low
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [dvs_pkg::DATA_W-1:0] element_value,
  // result side: one transfer per cycle while strobe is high
  output logic                                   strobe,
  output logic signed [dvs_pkg::DATA_W-1:0]      sorted_value,
  output logic                                   final_flag
);

  // command and status between controller and cell row
  dvs_pkg::cmd_t    cmd;
  dvs_pkg::status_t status;

  // controller: fill state takes values, drain state streams them out
  dvs_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy),
    .strobe     (strobe),
    .final_flag (final_flag)
  );

  // datapath: sorted row of insertion cells, head cell feeds the output
  dvs_datapath #(
    .ELEMENT_COUNT (ELEMENT_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .element_value (element_value),
    .status        (status),
    .head_value    (sorted_value)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/dvs_datapath.sv =====
`default_nettype none
module dvs_datapath #(
  parameter int ELEMENT_COUNT = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire dvs_pkg::cmd_t                    cmd,
  input  wire logic signed [dvs_pkg::DATA_W-1:0] element_value,
  output dvs_pkg::status_t                      status,
  output logic signed [dvs_pkg::DATA_W-1:0]     head_value
);

  localparam int CW = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
  localparam logic [CW-1:0] LAST = CW'(ELEMENT_COUNT - 1);

  logic signed [dvs_pkg::DATA_W-1:0] cells [ELEMENT_COUNT];
  logic signed [dvs_pkg::DATA_W-1:0] cells_next [ELEMENT_COUNT];
  logic [ELEMENT_COUNT-1:0]          lt;
  logic [CW-1:0]                     count;

  assign status.count_last = (count == LAST);
  assign head_value = cells[0];

  // new value goes before cell i when that cell is empty or holds a larger value
  always_comb begin
    for (int i = 0; i < ELEMENT_COUNT; i++) begin
      lt[i] = (CW'(i) >= count) || (element_value < cells[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < ELEMENT_COUNT; i++) begin
      cells_next[i] = cells[i];
      if (cmd.insert) begin
        if (lt[i]) begin
          if (i > 0 && lt[(i > 0) ? i - 1 : 0]) begin
            cells_next[i] = cells[(i > 0) ? i - 1 : 0];
          end else begin
            cells_next[i] = element_value;
          end
        end
      end else if (cmd.shift && i < ELEMENT_COUNT - 1) begin
        cells_next[i] = cells[(i < ELEMENT_COUNT - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ELEMENT_COUNT; i++) begin
      cells[i] <= cells_next[i];
    end
  end

  // one counter serves both filling and draining
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.insert || cmd.shift) begin
      count <= status.count_last ? '0 : count + CW'(1);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dvs_controller.sv =====
`default_nettype none
`include "diagonal_value_sorter_top_defines.svh"
module dvs_controller (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire dvs_pkg::status_t status,
  output dvs_pkg::cmd_t         cmd,
  output logic                  busy,
  output logic                  strobe,
  output logic                  final_flag
);

  dvs_pkg::state_t state;
  dvs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dvs_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dvs_pkg::ST_LOAD: begin
        if (start && status.count_last) begin
          state_next = dvs_pkg::ST_DRAIN;
        end
      end
      dvs_pkg::ST_DRAIN: begin
        if (status.count_last) begin
          state_next = dvs_pkg::ST_LOAD;
        end
      end
      default: state_next = dvs_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd.insert = 1'b0;
    cmd.shift  = 1'b0;
    busy       = 1'b0;
    strobe     = 1'b0;
    case (state)
      dvs_pkg::ST_LOAD: begin
        cmd.insert = start;
      end
      dvs_pkg::ST_DRAIN: begin
        cmd.shift = 1'b1;
        busy      = 1'b1;
        strobe    = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign final_flag = strobe && status.count_last;

  // filling the last slot starts the result burst
  `DVS_ASSERT_NEXT(a_fill_to_drain, clk, rst, cmd.insert && status.count_last, strobe)
  // the burst is unbroken until the final result
  `DVS_ASSERT_NEXT(a_burst_unbroken, clk, rst, strobe && !final_flag, strobe)
  // after the final result the block is ready again
  `DVS_ASSERT_NEXT(a_ready_after_final, clk, rst, final_flag, !busy && !strobe)
  // no value is taken in while results stream out
  `DVS_ASSERT_SAME(a_no_insert_in_drain, clk, rst, strobe, !cmd.insert)

endmodule
`default_nettype wire
